### design/mips1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips1_pkg: shared types and constants
// Opcodes, function codes, exception codes, request kinds and the structs
// used by the core sequencer and its multiply/divide unit.
// ----------------------------------------------------------------------------
package mips1_pkg;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_COP   = 2'd3
  } kind_e;

  localparam logic [31:0] RESET_VECTOR = 32'hBFC0_0000;
  localparam logic [31:0] BOOT_HANDLER = 32'hBFC0_0180;
  localparam logic [31:0] RAM_HANDLER  = 32'h8000_0080;
  localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
  localparam logic [31:0] SEGMENT_MASK = 32'hF000_0000;
  localparam logic [31:0] PRID_VALUE   = 32'd2;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_COP0    = 6'd16;
  localparam logic [5:0] OP_COP1    = 6'd17;
  localparam logic [5:0] OP_COP2    = 6'd18;
  localparam logic [5:0] OP_COP3    = 6'd19;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LWL     = 6'd34;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_LWR     = 6'd38;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SWL     = 6'd42;
  localparam logic [5:0] OP_SW      = 6'd43;
  localparam logic [5:0] OP_SWR     = 6'd46;
  localparam logic [5:0] OP_LWC0    = 6'd48;
  localparam logic [5:0] OP_LWC1    = 6'd49;
  localparam logic [5:0] OP_LWC2    = 6'd50;
  localparam logic [5:0] OP_LWC3    = 6'd51;
  localparam logic [5:0] OP_SWC0    = 6'd56;
  localparam logic [5:0] OP_SWC1    = 6'd57;
  localparam logic [5:0] OP_SWC2    = 6'd58;
  localparam logic [5:0] OP_SWC3    = 6'd59;

  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_BREAK   = 6'd13;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;
  localparam logic [5:0] FN_RFE     = 6'd16;

  localparam logic [4:0] COP0_MF = 5'd0;
  localparam logic [4:0] COP0_MT = 5'd4;
  localparam logic [4:0] COP0_CO = 5'd16;

  localparam logic [4:0] CP0_JUMPDEST = 5'd6;
  localparam logic [4:0] CP0_SR       = 5'd12;
  localparam logic [4:0] CP0_CAUSE    = 5'd13;
  localparam logic [4:0] CP0_EPC      = 5'd14;
  localparam logic [4:0] CP0_PRID     = 5'd15;

  localparam logic [4:0] EXC_INT  = 5'd0;
  localparam logic [4:0] EXC_ADEL = 5'd4;
  localparam logic [4:0] EXC_ADES = 5'd5;
  localparam logic [4:0] EXC_SYS  = 5'd8;
  localparam logic [4:0] EXC_BP   = 5'd9;
  localparam logic [4:0] EXC_RI   = 5'd10;
  localparam logic [4:0] EXC_CPU  = 5'd11;
  localparam logic [4:0] EXC_OV   = 5'd12;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef struct packed {
    logic start;
    logic div;
    logic sgn;
  } md_req_t;

  typedef struct packed {
    logic [4:0]  idx;
    logic [31:0] val;
  } load_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [3:0]  be;
    logic        exc;
    logic [4:0]  code;
  } res_t;

endpackage

### design/mips1_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips1_regfile: general register file
// One write port, one registered read port. Per-entry valid bits make
// never-written entries read as zero; entry zero always reads zero.
// ----------------------------------------------------------------------------
module mips1_regfile #(
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [31:0]              rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [31:0]              wr_data_i
);
  localparam int unsigned AW = $clog2(Depth);

  logic [31:0]    mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [31:0]    data_q;
  logic           hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      hit_q <= vld_q[rd_addr_i] && (rd_addr_i != '0);
      if (wr_en_i && (wr_addr_i != '0)) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= mem_q[rd_addr_i];
    if (wr_en_i && (wr_addr_i != AW'(0))) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = hit_q ? data_q : 32'd0;

endmodule

### design/mips1_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips1_muldiv: iterative multiply/divide unit
// Shift-add multiply and restoring divide on magnitudes, one bit per cycle,
// followed by a sign fix-up step.
// ----------------------------------------------------------------------------
module mips1_muldiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mips1_pkg::md_req_t req_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output logic               done_o,
  output logic [31:0]        hi_o,
  output logic [31:0]        lo_o
);
  import mips1_pkg::*;

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_RUN  = 4'b0010,
    MD_FIX  = 4'b0100,
    MD_DONE = 4'b1000
  } md_state_e;

  md_state_e   state_q, state_d;
  logic [31:0] hi_q, lo_q, opnd_q;
  logic [4:0]  cnt_q;
  logic        div_q, negq_q, negr_q;
  logic        na, nb;
  logic [31:0] ua, ub;
  logic [32:0] msum;
  logic [32:0] rsh;
  logic [33:0] diff;
  logic [63:0] prod_neg;

  assign na = req_i.sgn & a_i[31];
  assign nb = req_i.sgn & b_i[31];
  assign ua = na ? (32'd0 - a_i) : a_i;
  assign ub = nb ? (32'd0 - b_i) : b_i;

  assign msum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opnd_q} : 33'd0);
  assign rsh      = {hi_q, lo_q[31]};
  assign diff     = {1'b0, rsh} - {2'b00, opnd_q};
  assign prod_neg = 64'd0 - {hi_q, lo_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (req_i.start) state_d = MD_RUN;
      MD_RUN:  if (cnt_q == 5'd31) state_d = MD_FIX;
      MD_FIX:  state_d = MD_DONE;
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MD_RUN) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          hi_q   <= '0;
          lo_q   <= ua;
          opnd_q <= ub;
          div_q  <= req_i.div;
          negq_q <= na ^ nb;
          negr_q <= na;
        end
      end
      MD_RUN: begin
        if (div_q) begin
          hi_q <= diff[33] ? rsh[31:0] : diff[31:0];
          lo_q <= {lo_q[30:0], ~diff[33]};
        end else begin
          hi_q <= msum[32:1];
          lo_q <= {msum[0], lo_q[31:1]};
        end
      end
      MD_FIX: begin
        if (div_q) begin
          if (negq_q) lo_q <= 32'd0 - lo_q;
          if (negr_q) hi_q <= 32'd0 - hi_q;
        end else if (negq_q) begin
          hi_q <= prod_neg[63:32];
          lo_q <= prod_neg[31:0];
        end
      end
      MD_DONE: ;
      default: ;
    endcase
  end

  assign done_o = (state_q == MD_DONE);
  assign hi_o   = hi_q;
  assign lo_o   = lo_q;

endmodule

### design/mips1_integer_core_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips1_integer_core_step: MIPS-I integer core, one item per step
// Executes one instruction word (or finishes one load) per input item and
// answers with one request item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): func_i selects an instruction
//   word at the announced fetch address (0) or read data for the pending
//   load (1); irq_pending_i carries the external interrupt lines.
//   Output channel (out_valid_o / out_stall_i): one request per input item:
//   fetch, read, write with byte enables, or unsupported coprocessor op,
//   plus exception flag and code.
//   Each item passes S_RDA, S_RDB, S_EXEC, S_WB1, S_WB2 and S_DONE; multiply
//   and divide also wait in S_MD for the bit-serial multiply/divide unit
//   (one iteration per operand bit plus setup and sign fix-up). The register
//   file read port is shared by both source operands, one read per cycle.
//   One item is in work at a time; in_stall_o is high from accept until the
//   sequencer returns to idle. A finished result waits in the output
//   register while the next item is taken; if the receiver still stalls
//   when the next result is ready, the sequencer holds it.
//   Reset: fetch address 0xBFC00000, all registers zero, processor id 2.
// ----------------------------------------------------------------------------
module mips1_integer_core_step #(
  parameter int unsigned GPR_COUNT    = 32,
  parameter int unsigned SYSCTL_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] data_word_i,
  input  logic [5:0]  irq_pending_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] address_o,
  output logic [31:0] write_data_o,
  output logic [3:0]  byte_enable_o,
  output logic        exception_taken_o,
  output logic [4:0]  exception_code_o
);
  import mips1_pkg::*;

  localparam int unsigned GAW = $clog2(GPR_COUNT);
  localparam int unsigned SAW = $clog2(SYSCTL_COUNT);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDA  = 8'b0000_0010,
    S_RDB  = 8'b0000_0100,
    S_EXEC = 8'b0000_1000,
    S_MD   = 8'b0001_0000,
    S_WB1  = 8'b0010_0000,
    S_WB2  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  logic        fn_q;
  logic [31:0] w_q, a_q;
  logic [5:0]  irq_q;
  logic [31:0] rd_data;
  logic [GAW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;

  logic [31:0] fetch_q, fetch_d, follow_q, follow_d, xpc_q, xpc_d;
  logic [3:0]  flags_q, flags_d;
  logic [31:0] sys_q [SYSCTL_COUNT];
  logic [31:0] sys_d [SYSCTL_COUNT];
  logic [31:0] hi_q, hi_d, lo_q, lo_d, held_q, held_d;
  logic        await_q, await_d;
  load_t       pend_q, pend_d, nload_q, nload_d, put_q, put_d;
  logic        put_we_q, put_we_d, dly_we, retire_q, retire_d;
  logic        md_go, md_div, md_sgn;
  md_req_t     md_req;
  logic        md_done;
  logic [31:0] md_hi, md_lo;
  res_t        res_q, res_d, out_q;
  logic        out_valid_q;
  logic        in_acc, out_free;

  logic [31:0] w, a, b, imm, zimm, ea, sum, dif, tgt, old_v, ld_v, sr, cause, epc;
  logic [5:0]  op, fn6;
  logic [4:0]  rs, rt, rd, sa, ecode;
  logic [4:0]  sh;
  logic        exc, tst;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign rd_addr = (state_q == S_RDA) ?
                   (await_q ? held_q[21+:GAW] : w_q[21+:GAW]) :
                   (await_q ? held_q[16+:GAW] : w_q[16+:GAW]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = put_q.idx[GAW-1:0];
    wr_data = put_q.val;
    if (state_q == S_WB1) begin
      wr_en = put_we_q;
    end else if (state_q == S_WB2) begin
      wr_en   = retire_q;
      wr_addr = pend_q.idx[GAW-1:0];
      wr_data = pend_q.val;
    end
  end

  mips1_regfile #(
    .Depth(GPR_COUNT)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign md_req.start = (state_q == S_EXEC) && md_go;
  assign md_req.div   = md_div;
  assign md_req.sgn   = md_sgn;

  mips1_muldiv u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (md_req),
    .a_i   (a_q),
    .b_i   (rd_data),
    .done_o(md_done),
    .hi_o  (md_hi),
    .lo_o  (md_lo)
  );

  always_comb begin
    fetch_d  = fetch_q;
    follow_d = follow_q;
    xpc_d    = xpc_q;
    flags_d  = flags_q;
    sys_d    = sys_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    held_d   = held_q;
    await_d  = await_q;
    pend_d   = pend_q;
    nload_d  = nload_q;
    put_we_d = 1'b0;
    put_d    = '0;
    dly_we   = 1'b0;
    retire_d = 1'b0;
    md_go    = 1'b0;
    md_div   = 1'b0;
    md_sgn   = 1'b0;
    res_d    = '0;
    res_d.kind = KIND_FETCH;
    exc      = 1'b0;
    ecode    = EXC_INT;
    tst      = 1'b0;
    old_v    = '0;
    ld_v     = '0;

    w    = await_q ? held_q : w_q;
    op   = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    sa   = w[10:6];
    fn6  = w[5:0];
    imm  = {{16{w[15]}}, w[15:0]};
    zimm = {16'd0, w[15:0]};
    a    = a_q;
    b    = rd_data;
    ea   = a + imm;
    sh   = {ea[1:0], 3'b000};
    sum  = '0;
    dif  = '0;
    tgt  = '0;

    if (await_q) begin
      if (fn_q) begin
        old_v = (pend_q.idx == rt) ? pend_q.val : b;
        case (op)
          OP_LB:  ld_v = {{24{ea[1] ? (ea[0] ? w_q[31] : w_q[23]) :
                                      (ea[0] ? w_q[15] : w_q[7])}},
                          8'(w_q >> sh)};
          OP_LBU: ld_v = {24'd0, 8'(w_q >> sh)};
          OP_LH:  ld_v = ea[1] ? {{16{w_q[31]}}, w_q[31:16]} :
                                 {{16{w_q[15]}}, w_q[15:0]};
          OP_LHU: ld_v = ea[1] ? {16'd0, w_q[31:16]} : {16'd0, w_q[15:0]};
          OP_LWL: begin
            case (ea[1:0])
              2'd0:    ld_v = {w_q[7:0], old_v[23:0]};
              2'd1:    ld_v = {w_q[15:0], old_v[15:0]};
              2'd2:    ld_v = {w_q[23:0], old_v[7:0]};
              default: ld_v = w_q;
            endcase
          end
          OP_LWR: begin
            case (ea[1:0])
              2'd0:    ld_v = w_q;
              2'd1:    ld_v = {old_v[31:24], w_q[31:8]};
              2'd2:    ld_v = {old_v[31:16], w_q[31:16]};
              default: ld_v = {old_v[31:8], w_q[31:24]};
            endcase
          end
          default: ld_v = w_q;
        endcase
        dly_we   = 1'b1;
        nload_d  = '{idx: rt, val: ld_v};
        await_d  = 1'b0;
        retire_d = 1'b1;
      end else begin
        res_d.kind = KIND_READ;
        res_d.addr = {ea[31:2], 2'b00};
      end
    end else if (!fn_q) begin
      flags_d = {flags_q[1:0], 2'b00};
      sys_d[CP0_CAUSE[SAW-1:0]][15:10] = irq_q;
      if (((sys_d[CP0_CAUSE[SAW-1:0]][15:8] & sys_d[CP0_SR[SAW-1:0]][15:8]) != 8'd0) &&
          sys_d[CP0_SR[SAW-1:0]][0] && (op != OP_COP2)) begin
        xpc_d    = fetch_q;
        exc      = 1'b1;
        ecode    = EXC_INT;
        retire_d = 1'b1;
      end else begin
        held_d   = w;
        xpc_d    = fetch_q;
        fetch_d  = follow_q;
        follow_d = follow_q + 32'd4;
        tgt      = follow_q + {imm[29:0], 2'b00};
        if (fetch_q[1:0] != 2'b00) begin
          exc   = 1'b1;
          ecode = EXC_ADEL;
        end else begin
          retire_d = 1'b1;
          case (op)
            OP_SPECIAL: begin
              sum = a + b;
              dif = a - b;
              put_d.idx = rd;
              case (fn6)
                FN_SLL:  begin put_we_d = 1'b1; put_d.val = b << sa; end
                FN_SRL:  begin put_we_d = 1'b1; put_d.val = b >> sa; end
                FN_SRA:  begin put_we_d = 1'b1; put_d.val = $signed(b) >>> sa; end
                FN_SLLV: begin put_we_d = 1'b1; put_d.val = b << a[4:0]; end
                FN_SRLV: begin put_we_d = 1'b1; put_d.val = b >> a[4:0]; end
                FN_SRAV: begin put_we_d = 1'b1; put_d.val = $signed(b) >>> a[4:0]; end
                FN_JR, FN_JALR: begin
                  if (fn6 == FN_JALR) begin
                    put_we_d  = 1'b1;
                    put_d.val = follow_d;
                  end
                  flags_d[0] = 1'b1;
                  if (a[1:0] != 2'b00) begin
                    exc   = 1'b1;
                    ecode = EXC_ADEL;
                  end else begin
                    follow_d   = a;
                    flags_d[1] = 1'b1;
                  end
                end
                FN_SYSCALL: begin exc = 1'b1; ecode = EXC_SYS; end
                FN_BREAK:   begin exc = 1'b1; ecode = EXC_BP; end
                FN_MFHI: begin put_we_d = 1'b1; put_d.val = hi_q; end
                FN_MTHI: hi_d = a;
                FN_MFLO: begin put_we_d = 1'b1; put_d.val = lo_q; end
                FN_MTLO: lo_d = a;
                FN_MULT:  begin md_go = 1'b1; md_sgn = 1'b1; end
                FN_MULTU: md_go = 1'b1;
                FN_DIV:   begin md_go = 1'b1; md_div = 1'b1; md_sgn = 1'b1; end
                FN_DIVU:  begin md_go = 1'b1; md_div = 1'b1; end
                FN_ADD: begin
                  if (!(a[31] ^ b[31]) && (sum[31] ^ a[31])) begin
                    exc   = 1'b1;
                    ecode = EXC_OV;
                  end else begin
                    put_we_d  = 1'b1;
                    put_d.val = sum;
                  end
                end
                FN_ADDU: begin put_we_d = 1'b1; put_d.val = sum; end
                FN_SUB: begin
                  if ((a[31] ^ b[31]) && (dif[31] ^ a[31])) begin
                    exc   = 1'b1;
                    ecode = EXC_OV;
                  end else begin
                    put_we_d  = 1'b1;
                    put_d.val = dif;
                  end
                end
                FN_SUBU: begin put_we_d = 1'b1; put_d.val = dif; end
                FN_AND:  begin put_we_d = 1'b1; put_d.val = a & b; end
                FN_OR:   begin put_we_d = 1'b1; put_d.val = a | b; end
                FN_XOR:  begin put_we_d = 1'b1; put_d.val = a ^ b; end
                FN_NOR:  begin put_we_d = 1'b1; put_d.val = ~(a | b); end
                FN_SLT: begin
                  put_we_d  = 1'b1;
                  put_d.val = {31'd0, $signed(a) < $signed(b)};
                end
                FN_SLTU: begin put_we_d = 1'b1; put_d.val = {31'd0, a < b}; end
                default: begin exc = 1'b1; ecode = EXC_RI; end
              endcase
            end
            OP_REGIMM: begin
              tst        = a[31] ^ rt[0];
              flags_d[0] = 1'b1;
              if (rt[4:1] == 4'b1000) begin
                put_we_d = 1'b1;
                put_d    = '{idx: LINK_REG, val: follow_d};
              end
              if (tst) begin
                follow_d   = tgt;
                flags_d[1] = 1'b1;
              end
            end
            OP_J, OP_JAL: begin
              if (op == OP_JAL) begin
                put_we_d = 1'b1;
                put_d    = '{idx: LINK_REG, val: follow_d};
              end
              flags_d[0] = 1'b1;
              follow_d   = (fetch_d & SEGMENT_MASK) | {4'd0, w[25:0], 2'b00};
              flags_d[1] = 1'b1;
            end
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
              case (op)
                OP_BEQ:  tst = (a == b);
                OP_BNE:  tst = (a != b);
                OP_BLEZ: tst = a[31] || (a == 32'd0);
                default: tst = !a[31] && (a != 32'd0);
              endcase
              flags_d[0] = 1'b1;
              if (tst) begin
                follow_d   = tgt;
                flags_d[1] = 1'b1;
              end
            end
            OP_ADDI: begin
              sum = a + imm;
              if (!(a[31] ^ imm[31]) && (sum[31] ^ a[31])) begin
                exc   = 1'b1;
                ecode = EXC_OV;
              end else begin
                put_we_d = 1'b1;
                put_d    = '{idx: rt, val: sum};
              end
            end
            OP_ADDIU: begin put_we_d = 1'b1; put_d = '{idx: rt, val: ea}; end
            OP_SLTI: begin
              put_we_d = 1'b1;
              put_d    = '{idx: rt, val: {31'd0, $signed(a) < $signed(imm)}};
            end
            OP_SLTIU: begin
              put_we_d = 1'b1;
              put_d    = '{idx: rt, val: {31'd0, a < imm}};
            end
            OP_ANDI: begin put_we_d = 1'b1; put_d = '{idx: rt, val: a & zimm}; end
            OP_ORI:  begin put_we_d = 1'b1; put_d = '{idx: rt, val: a | zimm}; end
            OP_XORI: begin put_we_d = 1'b1; put_d = '{idx: rt, val: a ^ zimm}; end
            OP_LUI: begin
              put_we_d = 1'b1;
              put_d    = '{idx: rt, val: {w[15:0], 16'd0}};
            end
            OP_COP0: begin
              if (rs == COP0_MF) begin
                dly_we  = 1'b1;
                nload_d = '{idx: rt,
                            val: (32'(rd) < SYSCTL_COUNT) ? sys_d[rd[SAW-1:0]] : 32'd0};
              end else if (rs == COP0_MT) begin
                if (rd == CP0_CAUSE) begin
                  sys_d[CP0_CAUSE[SAW-1:0]][9:8] = b[9:8];
                end else if (32'(rd) < SYSCTL_COUNT) begin
                  sys_d[rd[SAW-1:0]] = b;
                end
              end else if ((rs == COP0_CO) && (fn6 == FN_RFE)) begin
                sys_d[CP0_SR[SAW-1:0]][3:0] = sys_d[CP0_SR[SAW-1:0]][5:2];
              end
            end
            OP_COP2, OP_LWC2, OP_SWC2: res_d.kind = KIND_COP;
            OP_COP1, OP_COP3, OP_LWC0, OP_LWC1, OP_LWC3,
            OP_SWC0, OP_SWC1, OP_SWC3: begin
              exc   = 1'b1;
              ecode = EXC_CPU;
            end
            OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR: begin
              if (((op == OP_LH || op == OP_LHU) && ea[0]) ||
                  ((op == OP_LW) && (ea[1:0] != 2'b00))) begin
                exc   = 1'b1;
                ecode = EXC_ADEL;
              end else begin
                await_d    = 1'b1;
                retire_d   = 1'b0;
                res_d.kind = KIND_READ;
                res_d.addr = {ea[31:2], 2'b00};
              end
            end
            OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR: begin
              if (((op == OP_SH) && ea[0]) ||
                  ((op == OP_SW) && (ea[1:0] != 2'b00))) begin
                exc   = 1'b1;
                ecode = EXC_ADES;
              end else if (!sys_d[CP0_SR[SAW-1:0]][16]) begin
                res_d.kind = KIND_WRITE;
                res_d.addr = {ea[31:2], 2'b00};
                case (op)
                  OP_SB: begin
                    res_d.data = {24'd0, b[7:0]} << sh;
                    res_d.be   = 4'b0001 << ea[1:0];
                  end
                  OP_SH: begin
                    res_d.data = ea[1] ? {b[15:0], 16'd0} : {16'd0, b[15:0]};
                    res_d.be   = ea[1] ? 4'b1100 : 4'b0011;
                  end
                  OP_SW: begin
                    res_d.data = b;
                    res_d.be   = 4'b1111;
                  end
                  OP_SWL: begin
                    case (ea[1:0])
                      2'd0:    begin res_d.data = b >> 24; res_d.be = 4'b0001; end
                      2'd1:    begin res_d.data = b >> 16; res_d.be = 4'b0011; end
                      2'd2:    begin res_d.data = b >> 8;  res_d.be = 4'b0111; end
                      default: begin res_d.data = b;       res_d.be = 4'b1111; end
                    endcase
                  end
                  default: begin
                    res_d.data = b << sh;
                    case (ea[1:0])
                      2'd0:    res_d.be = 4'b1111;
                      2'd1:    res_d.be = 4'b1110;
                      2'd2:    res_d.be = 4'b1100;
                      default: res_d.be = 4'b1000;
                    endcase
                  end
                endcase
              end
            end
            default: begin exc = 1'b1; ecode = EXC_RI; end
          endcase
        end
      end
    end

    if ((put_we_d && (pend_q.idx == put_d.idx)) ||
        (dly_we && (pend_q.idx == nload_d.idx))) begin
      pend_d = '0;
    end

    sr    = sys_d[CP0_SR[SAW-1:0]];
    cause = sys_d[CP0_CAUSE[SAW-1:0]];
    epc   = xpc_d;
    if (exc) begin
      cause[31:30] = 2'b00;
      cause[6:2]   = ecode;
      if (flags_d[2]) begin
        epc       = xpc_d - 32'd4;
        cause[31] = 1'b1;
        cause[30] = flags_d[3];
        sys_d[CP0_JUMPDEST[SAW-1:0]] = fetch_d;
      end
      sys_d[CP0_SR[SAW-1:0]]    = {sr[31:6], sr[3:0], 2'b00};
      sys_d[CP0_CAUSE[SAW-1:0]] = cause;
      sys_d[CP0_EPC[SAW-1:0]]   = epc;
      fetch_d      = sr[22] ? BOOT_HANDLER : RAM_HANDLER;
      follow_d     = (sr[22] ? BOOT_HANDLER : RAM_HANDLER) + 32'd4;
      flags_d[1:0] = 2'b00;
      res_d.exc    = 1'b1;
      res_d.code   = ecode;
    end

    if ((res_d.kind == KIND_FETCH) || (res_d.kind == KIND_COP)) begin
      res_d.addr = fetch_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_RDA;
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_EXEC;
      S_EXEC: state_d = md_go ? S_MD : S_WB1;
      S_MD:   if (md_done) state_d = S_WB1;
      S_WB1:  state_d = S_WB2;
      S_WB2:  state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      fetch_q     <= RESET_VECTOR;
      follow_q    <= RESET_VECTOR + 32'd4;
      xpc_q       <= '0;
      flags_q     <= '0;
      for (int i = 0; i < SYSCTL_COUNT; i++) begin
        sys_q[i] <= '0;
      end
      sys_q[CP0_PRID[SAW-1:0]] <= PRID_VALUE;
      hi_q        <= '0;
      lo_q        <= '0;
      held_q      <= '0;
      await_q     <= 1'b0;
      pend_q      <= '0;
      nload_q     <= '0;
      put_we_q    <= 1'b0;
      retire_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_EXEC: begin
          fetch_q  <= fetch_d;
          follow_q <= follow_d;
          xpc_q    <= xpc_d;
          flags_q  <= flags_d;
          sys_q    <= sys_d;
          hi_q     <= hi_d;
          lo_q     <= lo_d;
          held_q   <= held_d;
          await_q  <= await_d;
          pend_q   <= pend_d;
          nload_q  <= nload_d;
          put_we_q <= put_we_d;
          retire_q <= retire_d;
        end
        S_MD: begin
          if (md_done) begin
            hi_q <= md_hi;
            lo_q <= md_lo;
          end
        end
        S_WB2: begin
          if (retire_q) begin
            pend_q  <= nload_q;
            nload_q <= '0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fn_q  <= func_i;
      w_q   <= data_word_i;
      irq_q <= irq_pending_i;
    end
    if (state_q == S_RDB) begin
      a_q <= rd_data;
    end
    if (state_q == S_EXEC) begin
      res_q <= res_d;
      put_q <= put_d;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign address_o         = out_q.addr;
  assign write_data_o      = out_q.data;
  assign byte_enable_o     = out_q.be;
  assign exception_taken_o = out_q.exc;
  assign exception_code_o  = out_q.code;

endmodule

### design/mips1_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips1_chk: port-level checker
// Watches the core's channels and request fields over time.
// ----------------------------------------------------------------------------
module mips1_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        func_i,
  input logic [31:0] data_word_i,
  input logic [5:0]  irq_pending_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [31:0] address_o,
  input logic [31:0] write_data_o,
  input logic [3:0]  byte_enable_o,
  input logic        exception_taken_o,
  input logic [4:0]  exception_code_o
);
  import mips1_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(address_o) && $stable(kind_o))
    else $error("stalled item changed");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_WRITE) |-> (byte_enable_o == 4'd0) &&
    (write_data_o == 32'd0))
    else $error("byte lanes outside a write");

  a_exc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exception_taken_o |-> (kind_o == KIND_FETCH))
    else $error("exception without handler fetch");

  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == KIND_READ) || (kind_o == KIND_WRITE)) |->
    (address_o[1:0] == 2'b00) && (!exception_taken_o || (exception_code_o != 5'd0)))
    else $error("unaligned access address");

endmodule

bind mips1_integer_core_step mips1_chk u_chk (.*);
